// File: hw/rtl/ede_pkg.sv
// Shared types and constants for the edit distance engine.
package ede_pkg;

    localparam int EDE_MAX_LEN = 32;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 6;
    localparam int SAT_W       = DIST_W + 1;
    localparam logic [SAT_W-1:0] DIST_SAT = SAT_W'((1 << DIST_W) - 1);

    typedef enum logic {
        CMD_REF  = 1'b0,
        CMD_CAND = 1'b1
    } t_cmd;

    typedef struct packed {
        logic vld;
        logic upd;
    } t_tok_ctl;

endpackage

// File: hw/rtl/edit_distance_engine.sv
// Top level of the Levenshtein edit distance engine with a chain of row cells.
//
//  Channel   Handshake        Payload
//  input     start / busy     i_cmd, i_ch, i_last
//  result    o_done strobe    o_distance, o_too_long
//
// A reference character leaves busy low, so such transfers can follow back to back. A
// candidate character sends a token along the chain of MAX_LEN cells, one cell per cycle,
// and its transfer raises busy, which stays high until the token leaves the chain, so the
// next transfer waits for that. The result of a final candidate character is on the ports
// in the last busy cycle, as the token leaves the chain.
// Reset is synchronous and at once sets each row value to its cell index. The receiver cannot stall a result.
module edit_distance_engine #(
    parameter int MAX_LEN = ede_pkg::EDE_MAX_LEN
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  ede_pkg::t_cmd                 i_cmd,
    input  logic [ede_pkg::CHAR_W-1:0]    i_ch,
    input  logic                          i_last,
    output logic                          o_done,
    output logic [ede_pkg::DIST_W-1:0]    o_distance,
    output logic                          o_too_long
);
    import ede_pkg::*;

    localparam int W = $clog2(MAX_LEN + 1);

    logic [W-1:0]      r_ref_len,   n_ref_len;
    logic              r_load_done, n_load_done;
    logic              r_ovf,       n_ovf;
    logic [W-1:0]      r_cand_cnt,  n_cand_cnt;
    logic              r_cand_over, n_cand_over;
    logic [W-1:0]      r_dp0,       n_dp0;
    logic              r_busy,      n_busy;
    logic              r_fin,       n_fin;
    t_tok_ctl          r_tok,       n_tok;
    logic [W-1:0]      r_tok_new,   n_tok_new;
    logic [W-1:0]      r_tok_old,   n_tok_old;
    logic [CHAR_W-1:0] r_tok_ch;

    logic         c_accept;
    logic         c_rewind;
    logic         c_wr;
    logic         c_launch;
    logic [W-1:0] c_base_len;
    logic [W-1:0] c_cnt;
    logic [W-1:0] c_dp0;
    logic         c_over;
    logic         c_upd;

    t_tok_ctl          tok_chain [0:MAX_LEN];
    logic [W-1:0]      new_chain [0:MAX_LEN];
    logic [W-1:0]      old_chain [0:MAX_LEN];
    logic [CHAR_W-1:0] ch_chain  [0:MAX_LEN];
    logic [MAX_LEN:1]  wr_vec;
    logic [SAT_W-1:0]  end_dist;

    assign c_accept = start & ~r_busy;

    always_comb begin
        n_ref_len   = r_ref_len;
        n_load_done = r_load_done;
        n_ovf       = r_ovf;
        n_cand_cnt  = r_cand_cnt;
        n_cand_over = r_cand_over;
        n_dp0       = r_dp0;
        n_busy      = r_busy;
        n_fin       = r_fin;
        n_tok       = '0;
        n_tok_new   = r_tok_new;
        n_tok_old   = r_tok_old;
        c_rewind    = 1'b0;
        c_wr        = 1'b0;
        c_launch    = 1'b0;
        c_base_len  = r_load_done ? '0 : r_ref_len;
        c_cnt       = r_cand_cnt;
        c_dp0       = r_dp0;
        c_over      = r_cand_over;
        c_upd       = 1'b0;
        if (c_accept && i_cmd == CMD_REF) begin
            n_ovf = r_load_done ? 1'b0 : r_ovf;
            if (c_base_len < W'(MAX_LEN)) begin
                c_wr      = 1'b1;
                n_ref_len = c_base_len + 1'b1;
            end else begin
                n_ovf     = 1'b1;
                n_ref_len = c_base_len;
            end
            n_load_done = i_last;
            c_rewind    = r_load_done | i_last;
            if (c_rewind) begin
                n_dp0       = '0;
                n_cand_cnt  = '0;
                n_cand_over = 1'b0;
            end
        end else if (c_accept && i_cmd == CMD_CAND) begin
            c_rewind    = ~r_load_done;
            n_load_done = 1'b1;
            if (!r_load_done) begin
                c_cnt  = '0;
                c_dp0  = '0;
                c_over = 1'b0;
            end
            c_upd       = c_cnt < W'(MAX_LEN);
            c_launch    = 1'b1;
            n_tok.vld   = 1'b1;
            n_tok.upd   = c_upd;
            n_tok_old   = c_dp0;
            n_tok_new   = c_upd ? c_cnt + 1'b1 : c_dp0;
            n_dp0       = n_tok_new;
            n_cand_cnt  = c_upd ? c_cnt + 1'b1 : c_cnt;
            n_cand_over = c_over | ~c_upd;
            n_busy      = 1'b1;
            n_fin       = i_last;
        end else if (tok_chain[MAX_LEN].vld) begin
            n_busy = 1'b0;
            if (r_fin) begin
                c_rewind    = 1'b1;
                n_dp0       = '0;
                n_cand_cnt  = '0;
                n_cand_over = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_len   <= '0;
            r_load_done <= 1'b0;
            r_ovf       <= 1'b0;
            r_cand_cnt  <= '0;
            r_cand_over <= 1'b0;
            r_dp0       <= '0;
            r_busy      <= 1'b0;
            r_fin       <= 1'b0;
            r_tok       <= '0;
        end else begin
            r_ref_len   <= n_ref_len;
            r_load_done <= n_load_done;
            r_ovf       <= n_ovf;
            r_cand_cnt  <= n_cand_cnt;
            r_cand_over <= n_cand_over;
            r_dp0       <= n_dp0;
            r_busy      <= n_busy;
            r_fin       <= n_fin;
            r_tok       <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_new <= n_tok_new;
        r_tok_old <= n_tok_old;
        if (c_launch) begin
            r_tok_ch <= i_ch;
        end
    end

    assign tok_chain[0] = r_tok;
    assign new_chain[0] = r_tok_new;
    assign old_chain[0] = r_tok_old;
    assign ch_chain[0]  = r_tok_ch;

    for (genvar gi = 1; gi <= MAX_LEN; gi++) begin : g_cell
        assign wr_vec[gi] = c_wr & (c_base_len == W'(gi - 1));

        ede_cell #(
            .W     (W),
            .INDEX (gi)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (tok_chain[gi-1]),
            .i_new    (new_chain[gi-1]),
            .i_old    (old_chain[gi-1]),
            .i_ch     (ch_chain[gi-1]),
            .i_active (W'(gi) <= r_ref_len),
            .i_rewind (c_rewind),
            .i_wr_en  (wr_vec[gi]),
            .i_wr_ch  (i_ch),
            .o_tok    (tok_chain[gi]),
            .o_new    (new_chain[gi]),
            .o_old    (old_chain[gi]),
            .o_ch     (ch_chain[gi])
        );
    end

    assign end_dist   = SAT_W'(new_chain[MAX_LEN]);
    assign busy       = r_busy;
    assign o_done     = tok_chain[MAX_LEN].vld & r_fin;
    assign o_distance = (end_dist > DIST_SAT) ? DIST_SAT[DIST_W-1:0] : end_dist[DIST_W-1:0];
    assign o_too_long = r_ovf | r_cand_over;

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("Result transfer outside a candidate pass.");

    a_cand_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_CAND) |=> busy)
        else $error("Candidate transfer did not start a pass.");

    a_chain_end_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok_chain[MAX_LEN].vld |=> !busy)
        else $error("Engine stayed busy after the token left the chain.");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_vec))
        else $error("More than one cell written by one reference character.");

endmodule

// File: hw/rtl/ede_cell.sv
// One reference position of the systolic edit distance row.
module ede_cell #(
    parameter int W     = 6,
    parameter int INDEX = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ede_pkg::t_tok_ctl             i_tok,
    input  logic [W-1:0]                  i_new,
    input  logic [W-1:0]                  i_old,
    input  logic [ede_pkg::CHAR_W-1:0]    i_ch,
    input  logic                          i_active,
    input  logic                          i_rewind,
    input  logic                          i_wr_en,
    input  logic [ede_pkg::CHAR_W-1:0]    i_wr_ch,
    output ede_pkg::t_tok_ctl             o_tok,
    output logic [W-1:0]                  o_new,
    output logic [W-1:0]                  o_old,
    output logic [ede_pkg::CHAR_W-1:0]    o_ch
);
    import ede_pkg::*;

    logic [W-1:0]      r_dp;
    logic [CHAR_W-1:0] r_ref_ch;
    t_tok_ctl          r_tok;
    logic [W-1:0]      r_new;
    logic [W-1:0]      r_old;
    logic [CHAR_W-1:0] r_ch;

    logic [W:0]   c_diag;
    logic [W:0]   c_up;
    logic [W:0]   c_left;
    logic [W:0]   c_best;
    logic         c_upd;
    logic [W-1:0] n_new;

    always_comb begin
        c_diag = {1'b0, i_old} + {{W{1'b0}}, (r_ref_ch != i_ch)};
        c_up   = {1'b0, r_dp} + 1'b1;
        c_left = {1'b0, i_new} + 1'b1;
        c_best = c_diag;
        if (c_up < c_best) begin
            c_best = c_up;
        end
        if (c_left < c_best) begin
            c_best = c_left;
        end
        c_upd = i_tok.vld & i_tok.upd & i_active;
        if (!i_active) begin
            n_new = i_new;
        end else if (c_upd) begin
            n_new = c_best[W-1:0];
        end else begin
            n_new = r_dp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dp  <= W'(INDEX);
            r_tok <= '0;
        end else begin
            r_tok <= i_tok;
            if (i_rewind) begin
                r_dp <= W'(INDEX);
            end else if (c_upd) begin
                r_dp <= c_best[W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_new <= n_new;
        r_old <= r_dp;
        r_ch  <= i_ch;
        if (i_wr_en) begin
            r_ref_ch <= i_wr_ch;
        end
    end

    assign o_tok = r_tok;
    assign o_new = r_new;
    assign o_old = r_old;
    assign o_ch  = r_ch;

endmodule
